### sv/chtc_pkg.sv
// ----------------------------------------------------------------------------
// chtc_pkg: shared constants and helpers for the heading/thrust controller
// Holds the register map, reset values, fixed field widths and the angle
// wrap helper.
// ----------------------------------------------------------------------------
package chtc_pkg;

    // default width of the stored inner error
    localparam int ANGLE_WIDTH_DEF = 16;

    // shared multiplier operand widths (B holds a 20-bit gain plus sign)
    localparam int MUL_B_W     = 21;
    localparam int MUL_A_W_DEF = 17;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_HEADING   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL_THRUST     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_P_GAIN     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_INNER_D_GAIN     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUTER_P_GAIN     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CORRECTION_LIMIT = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_THRESHOLD  = 3'd6;

    // register reset values
    localparam logic signed [14:0] RST_TARGET_HEADING   = 15'sd5760;
    localparam logic signed [15:0] RST_TOTAL_THRUST     = 16'sd1024;
    localparam logic [19:0]        RST_INNER_P_GAIN     = 20'd4660;
    localparam logic [19:0]        RST_INNER_D_GAIN     = 20'd0;
    localparam logic [15:0]        RST_OUTER_P_GAIN     = 16'd0;
    localparam logic [13:0]        RST_CORRECTION_LIMIT = 14'd2880;
    localparam logic [23:0]        RST_SPEED_THRESHOLD  = 24'd66;

    // angles in 1/64 degree
    localparam logic signed [17:0] HALF_TURN   = 18'sd11520;
    localparam logic signed [17:0] FULL_TURN   = 18'sd23040;
    localparam logic signed [17:0] DOUBLE_TURN = 18'sd46080;

    // split is Q.16, saturated to +-1.0
    localparam int SPLIT_ONE = 65536;

    // Wrap an angle into [-180, 180) degrees. Inputs stay within two turns
    // of the range, so at most one double or single turn is folded back.
    function automatic logic signed [14:0] wrap_angle(input logic signed [17:0] a);
        logic signed [17:0] s;
        s = a + HALF_TURN;
        if (s < -FULL_TURN) begin
            s = s + DOUBLE_TURN;
        end else if (s < 18'sd0) begin
            s = s + FULL_TURN;
        end else if (s >= DOUBLE_TURN) begin
            s = s - DOUBLE_TURN;
        end else if (s >= FULL_TURN) begin
            s = s - FULL_TURN;
        end
        return 15'(s - HALF_TURN);
    endfunction

endpackage

### sv/cascaded_heading_thrust_controller_core.sv
// ----------------------------------------------------------------------------
// cascaded_heading_thrust_controller_core: cascaded P / PD heading controller
// Outer P loop shifts the heading setpoint; inner PD loop splits total thrust
// between left and right thrusters. One shared multiplier, small sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+--------------------------------
//  cfg     | in        | i_cfg_we             | i_cfg_index, i_cfg_data
//  in      | in        | i_in_valid/o_in_stall| gondola/velocity heading, speed
//  out     | out       | o_out_valid/i_out_stall | thrusts, setpoint, error
//
//  An item passes from its input transfer through OUTER, CORR, ERR, MUL_P,
//  MUL_D, SPLIT, MUL_L, MUL_R and DONE to its result loading the output
//  register; five products run one after another through the single
//  multiplier. The next item is taken the cycle after that load, not before.
//  A result waiting on a stalled output holds the sequencer in its last step.
//  Synchronous active-low reset restores register defaults and clears the
//  stored inner error.
// ----------------------------------------------------------------------------
module cascaded_heading_thrust_controller_core
    import chtc_pkg::*;
#(
    parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // configuration
    input  logic                     i_cfg_we,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    // input channel
    input  logic                     i_in_valid,
    output logic                     o_in_stall,
    input  logic signed [14:0]       i_gondola_heading,
    input  logic signed [14:0]       i_velocity_heading,
    input  logic [23:0]              i_gondola_speed,
    // output channel
    output logic                     o_out_valid,
    input  logic                     i_out_stall,
    output logic signed [15:0]       o_left_thrust,
    output logic signed [15:0]       o_right_thrust,
    output logic signed [15:0]       o_heading_setpoint,
    output logic signed [14:0]       o_heading_error
);

    // error change width and shared multiplier widths
    localparam int CW = ((ANGLE_WIDTH > 15) ? ANGLE_WIDTH : 15) + 1;
    localparam int PW = CW + MUL_B_W;

    localparam logic signed [CW-1:0] LIM_HI = CW'((1 << (ANGLE_WIDTH - 1)) - 1);
    localparam logic signed [CW-1:0] LIM_LO = -LIM_HI - CW'(1);

    // sequencer codes
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_OUTER = 4'd1;
    localparam logic [3:0] ST_CORR  = 4'd2;
    localparam logic [3:0] ST_ERR   = 4'd3;
    localparam logic [3:0] ST_MUL_P = 4'd4;
    localparam logic [3:0] ST_MUL_D = 4'd5;
    localparam logic [3:0] ST_SPLIT = 4'd6;
    localparam logic [3:0] ST_MUL_L = 4'd7;
    localparam logic [3:0] ST_MUL_R = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    // configuration registers
    logic signed [14:0] r_target_heading;
    logic signed [15:0] r_total_thrust;
    logic [19:0]        r_inner_p_gain;
    logic [19:0]        r_inner_d_gain;
    logic [15:0]        r_outer_p_gain;
    logic [13:0]        r_correction_limit;
    logic [23:0]        r_speed_threshold;

    // control
    logic [3:0]         r_state;
    logic [3:0]         n_state;
    logic               r_out_valid;
    logic signed [ANGLE_WIDTH-1:0] r_prev;

    // working registers
    logic signed [14:0] r_heading;
    logic signed [14:0] r_target;
    logic signed [14:0] r_oerr;
    logic signed [15:0] r_setpoint;
    logic signed [14:0] r_err;
    logic signed [CW-1:0] r_change;
    logic signed [PW-1:0] r_acc;
    logic signed [17:0] r_split;
    logic signed [15:0] r_left;

    // output registers
    logic signed [15:0] r_out_left;
    logic signed [15:0] r_out_right;
    logic signed [15:0] r_out_setpoint;
    logic signed [14:0] r_out_err;

    logic               w_in_xfer;
    logic               w_out_free;
    logic signed [14:0] w_head_sel;
    logic signed [14:0] w_target;
    logic               w_mul_en;
    logic signed [CW-1:0]      w_mul_a;
    logic signed [MUL_B_W-1:0] w_mul_b;
    logic signed [PW-1:0]      w_prod;
    logic signed [PW-1:0]      w_prod_sh;
    logic signed [PW-1:0]      w_lim;
    logic signed [14:0]        w_corr;
    logic signed [16:0]        w_setpoint;
    logic signed [14:0]        w_err;
    logic signed [CW-1:0]      w_err_ext;
    logic signed [CW-1:0]      w_prev_ext;
    logic signed [CW-1:0]      w_err_sat;
    logic signed [PW:0]        w_sum;
    logic signed [PW:0]        w_sum_sh;
    logic signed [17:0]        w_split;
    logic signed [15:0]        w_right;

    assign w_in_xfer  = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != ST_IDLE);

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_heading   <= RST_TARGET_HEADING;
            r_total_thrust     <= RST_TOTAL_THRUST;
            r_inner_p_gain     <= RST_INNER_P_GAIN;
            r_inner_d_gain     <= RST_INNER_D_GAIN;
            r_outer_p_gain     <= RST_OUTER_P_GAIN;
            r_correction_limit <= RST_CORRECTION_LIMIT;
            r_speed_threshold  <= RST_SPEED_THRESHOLD;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_TARGET_HEADING:   r_target_heading   <= i_cfg_data[14:0];
                REG_TOTAL_THRUST:     r_total_thrust     <= i_cfg_data[15:0];
                REG_INNER_P_GAIN:     r_inner_p_gain     <= i_cfg_data[19:0];
                REG_INNER_D_GAIN:     r_inner_d_gain     <= i_cfg_data[19:0];
                REG_OUTER_P_GAIN:     r_outer_p_gain     <= i_cfg_data[15:0];
                REG_CORRECTION_LIMIT: r_correction_limit <= i_cfg_data[13:0];
                REG_SPEED_THRESHOLD:  r_speed_threshold  <= i_cfg_data[23:0];
                default: ;
            endcase
        end
    end

    // heading choice, wrapped target and outer error at the input transfer
    assign w_head_sel = (i_gondola_speed > r_speed_threshold) ? i_velocity_heading
                                                               : i_gondola_heading;
    assign w_target   = wrap_angle(18'(r_target_heading));

    // outer correction: (err * gain) >>> 12, clamped to +-limit
    assign w_prod_sh = w_prod >>> 12;
    assign w_lim     = PW'($signed({1'b0, r_correction_limit}));
    always_comb begin
        if (w_prod_sh > w_lim) begin
            w_corr = 15'(w_lim);
        end else if (w_prod_sh < -w_lim) begin
            w_corr = 15'(-w_lim);
        end else begin
            w_corr = 15'(w_prod_sh);
        end
    end
    assign w_setpoint = 17'(r_target) - 17'(w_corr);

    // inner error, its change and the saturated copy kept for next tick
    assign w_err      = wrap_angle(18'(r_heading) - 18'(r_setpoint));
    assign w_err_ext  = CW'(w_err);
    assign w_prev_ext = CW'(r_prev);
    always_comb begin
        if (w_err_ext > LIM_HI) begin
            w_err_sat = LIM_HI;
        end else if (w_err_ext < LIM_LO) begin
            w_err_sat = LIM_LO;
        end else begin
            w_err_sat = w_err_ext;
        end
    end

    // split: (e*P + de*D) >>> 10, saturated to +-1.0
    assign w_sum    = (PW+1)'(r_acc) + (PW+1)'(w_prod);
    assign w_sum_sh = w_sum >>> 10;
    always_comb begin
        if (w_sum_sh > (PW+1)'(SPLIT_ONE)) begin
            w_split = 18'(SPLIT_ONE);
        end else if (w_sum_sh < -((PW+1)'(SPLIT_ONE))) begin
            w_split = -18'(SPLIT_ONE);
        end else begin
            w_split = 18'(w_sum_sh);
        end
    end

    assign w_right = 16'(w_prod >>> 17);

    // shared multiplier operand select
    always_comb begin
        w_mul_en = 1'b1;
        w_mul_a  = CW'(r_oerr);
        w_mul_b  = MUL_B_W'($signed({1'b0, r_outer_p_gain}));
        case (r_state)
            ST_OUTER: begin
                w_mul_a = CW'(r_oerr);
                w_mul_b = MUL_B_W'($signed({1'b0, r_outer_p_gain}));
            end
            ST_MUL_P: begin
                w_mul_a = CW'(r_err);
                w_mul_b = MUL_B_W'($signed({1'b0, r_inner_p_gain}));
            end
            ST_MUL_D: begin
                w_mul_a = r_change;
                w_mul_b = MUL_B_W'($signed({1'b0, r_inner_d_gain}));
            end
            ST_MUL_L: begin
                w_mul_a = CW'(r_total_thrust);
                w_mul_b = MUL_B_W'(SPLIT_ONE) + MUL_B_W'(r_split);
            end
            ST_MUL_R: begin
                w_mul_a = CW'(r_total_thrust);
                w_mul_b = MUL_B_W'(SPLIT_ONE) - MUL_B_W'(r_split);
            end
            default: begin
                w_mul_en = 1'b0;
            end
        endcase
    end

    chtc_mul #(
        .A_W (CW),
        .B_W (MUL_B_W)
    ) u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (w_mul_a),
        .i_b    (w_mul_b),
        .o_prod (w_prod)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (w_in_xfer) n_state = ST_OUTER;
            ST_OUTER: n_state = ST_CORR;
            ST_CORR:  n_state = ST_ERR;
            ST_ERR:   n_state = ST_MUL_P;
            ST_MUL_P: n_state = ST_MUL_D;
            ST_MUL_D: n_state = ST_SPLIT;
            ST_SPLIT: n_state = ST_MUL_L;
            ST_MUL_L: n_state = ST_MUL_R;
            ST_MUL_R: n_state = ST_DONE;
            ST_DONE:  if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_prev      <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_DONE && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == ST_ERR) begin
                r_prev <= ANGLE_WIDTH'(w_err_sat);
            end
        end
    end

    // working and output registers
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_heading <= w_head_sel;
            r_target  <= w_target;
            r_oerr    <= wrap_angle(18'(w_head_sel) - 18'(w_target));
        end
        if (r_state == ST_CORR) begin
            r_setpoint <= 16'(w_setpoint);
        end
        if (r_state == ST_ERR) begin
            r_err    <= w_err;
            r_change <= w_err_ext - w_prev_ext;
        end
        if (r_state == ST_MUL_D) begin
            r_acc <= w_prod;
        end
        if (r_state == ST_SPLIT) begin
            r_split <= w_split;
        end
        if (r_state == ST_MUL_R) begin
            r_left <= 16'(w_prod >>> 17);
        end
        if (r_state == ST_DONE && w_out_free) begin
            r_out_left     <= r_left;
            r_out_right    <= w_right;
            r_out_setpoint <= r_setpoint;
            r_out_err      <= r_err;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_left_thrust      = r_out_left;
    assign o_right_thrust     = r_out_right;
    assign o_heading_setpoint = r_out_setpoint;
    assign o_heading_error    = r_out_err;

`ifndef NO_ASSERTIONS
    // an input transfer starts the sequence
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> (r_state == ST_OUTER))
        else $error("sequencer did not start after input transfer");

    // a new result only ever comes from the last step
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> ($past(r_state) == ST_DONE))
        else $error("result loaded outside final step");

    // saturated split stays within +-1.0 when used
    a_split_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL_L) |->
            (r_split <= 18'sd65536) && (r_split >= -18'sd65536))
        else $error("thrust split out of range");

    // setpoint stays within target +- the largest correction
    a_setpoint_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ERR) |->
            (r_setpoint <= 16'sd27902) && (r_setpoint >= -16'sd27903))
        else $error("heading setpoint out of range");
`endif

endmodule

### sv/chtc_mul.sv
// ----------------------------------------------------------------------------
// chtc_mul: shared signed multiplier with registered product
// One product per enabled cycle; the product holds while not enabled.
// ----------------------------------------------------------------------------
module chtc_mul
    import chtc_pkg::*;
#(
    parameter int A_W = MUL_A_W_DEF,
    parameter int B_W = MUL_B_W
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic signed [A_W-1:0]    i_a,
    input  logic signed [B_W-1:0]    i_b,
    output logic signed [A_W+B_W-1:0] o_prod
);

    logic signed [A_W+B_W-1:0] r_prod;
    logic signed [A_W+B_W-1:0] n_prod;

    // full-precision signed product
    always_comb begin
        n_prod = (A_W+B_W)'(i_a) * (A_W+B_W)'(i_b);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= n_prod;
        end
    end

    assign o_prod = r_prod;

endmodule

### verif/tb_cascaded_heading_thrust_controller_core.sv
// ----------------------------------------------------------------------------
// tb_cascaded_heading_thrust_controller_core: self-checking bench
// Drives control ticks through the valid/stall channels across several
// register settings and idling mixes. A scoreboard predicts the left/right
// thrust, setpoint and wrapped error of every tick and checks each result
// transfer in order.
// ----------------------------------------------------------------------------
module tb_cascaded_heading_thrust_controller_core;
    import chtc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_TICKS = 205;
    localparam longint ERR_MAX = (longint'(1) <<< (ANGLE_WIDTH_DEF - 1)) - 1;
    // index past the register map, written once to show it is ignored
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    typedef struct packed {
        logic signed [15:0] left_thrust;
        logic signed [15:0] right_thrust;
        logic signed [15:0] heading_setpoint;
        logic signed [14:0] heading_error;
    } t_drive;

    // Register copy, stored inner error and queue of predicted drive results
    class t_heading_drive_model;
        logic signed [14:0] target_heading;
        logic signed [15:0] total_thrust;
        logic [19:0]        inner_p_gain;
        logic [19:0]        inner_d_gain;
        logic [15:0]        outer_p_gain;
        logic [13:0]        correction_limit;
        logic [23:0]        speed_threshold;
        longint             last_error;
        t_drive             expected_drives[$];
        int                 mismatches;
        int                 ticks;
        int                 drives;

        function new();
            target_heading   = RST_TARGET_HEADING;
            total_thrust     = RST_TOTAL_THRUST;
            inner_p_gain     = RST_INNER_P_GAIN;
            inner_d_gain     = RST_INNER_D_GAIN;
            outer_p_gain     = RST_OUTER_P_GAIN;
            correction_limit = RST_CORRECTION_LIMIT;
            speed_threshold  = RST_SPEED_THRESHOLD;
            last_error       = 0;
            mismatches       = 0;
            ticks            = 0;
            drives           = 0;
        endfunction

        function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_TARGET_HEADING:   target_heading   = data[14:0];
                REG_TOTAL_THRUST:     total_thrust     = data[15:0];
                REG_INNER_P_GAIN:     inner_p_gain     = data[19:0];
                REG_INNER_D_GAIN:     inner_d_gain     = data[19:0];
                REG_OUTER_P_GAIN:     outer_p_gain     = data[15:0];
                REG_CORRECTION_LIMIT: correction_limit = data[13:0];
                REG_SPEED_THRESHOLD:  speed_threshold  = data[23:0];
                default: ;
            endcase
        endfunction

        // floor-modulo fold into [-half turn, half turn)
        static function longint fold_turn(input longint a);
            longint r;
            r = (a + longint'(HALF_TURN)) % longint'(FULL_TURN);
            if (r < 0) begin
                r = r + longint'(FULL_TURN);
            end
            return r - longint'(HALF_TURN);
        endfunction

        function int pending();
            return expected_drives.size();
        endfunction

        // one accepted tick: outer P on setpoint, inner PD on thrust split
        function void record_tick(input logic signed [14:0] g_head,
                                  input logic signed [14:0] v_head,
                                  input logic [23:0] speed);
            longint tgt, hdg, corr, lim, setp, err, change, split, lft, rgt;
            t_drive exp_drive;
            tgt = fold_turn(longint'(target_heading));
            target_heading = tgt[14:0];
            hdg = (speed > speed_threshold) ? longint'(v_head) : longint'(g_head);
            corr = (fold_turn(hdg - tgt) * longint'(outer_p_gain)) >>> 12;
            lim = longint'(correction_limit);
            if (corr > lim) begin
                corr = lim;
            end else if (corr < -lim) begin
                corr = -lim;
            end
            setp = tgt - corr;
            err = fold_turn(hdg - setp);
            change = err - last_error;
            // stored error saturates to the angle width
            if (err > ERR_MAX) begin
                last_error = ERR_MAX;
            end else if (err < -ERR_MAX - 1) begin
                last_error = -ERR_MAX - 1;
            end else begin
                last_error = err;
            end
            split = (err * longint'(inner_p_gain) + change * longint'(inner_d_gain)) >>> 10;
            if (split > longint'(SPLIT_ONE)) begin
                split = SPLIT_ONE;
            end else if (split < -longint'(SPLIT_ONE)) begin
                split = -longint'(SPLIT_ONE);
            end
            lft = (longint'(total_thrust) * (longint'(SPLIT_ONE) + split)) >>> 17;
            rgt = (longint'(total_thrust) * (longint'(SPLIT_ONE) - split)) >>> 17;
            exp_drive.left_thrust      = lft[15:0];
            exp_drive.right_thrust     = rgt[15:0];
            exp_drive.heading_setpoint = setp[15:0];
            exp_drive.heading_error    = err[14:0];
            expected_drives.push_back(exp_drive);
            ticks++;
        endfunction

        function void compare_field(input string name, input logic signed [15:0] want,
                                    input logic signed [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %0d got %0d", $time, name, want, got);
                mismatches++;
            end
        endfunction

        function void check_drive(input t_drive got);
            t_drive want;
            if (expected_drives.size() == 0) begin
                $display("%0t: result with nothing outstanding: left %0d right %0d sp %0d err %0d",
                         $time, got.left_thrust, got.right_thrust, got.heading_setpoint,
                         got.heading_error);
                mismatches++;
                return;
            end
            want = expected_drives.pop_front();
            drives++;
            compare_field("left_thrust", want.left_thrust, got.left_thrust);
            compare_field("right_thrust", want.right_thrust, got.right_thrust);
            compare_field("heading_setpoint", want.heading_setpoint, got.heading_setpoint);
            compare_field("heading_error", want.heading_error, got.heading_error);
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n            = 1'b0;
    logic                   i_cfg_we           = 1'b0;
    logic [CFG_IDX_W-1:0]   i_cfg_index        = REG_TARGET_HEADING;
    logic [CFG_DATA_W-1:0]  i_cfg_data         = '0;
    logic                   i_in_valid         = 1'b0;
    logic                   o_in_stall;
    logic signed [14:0]     i_gondola_heading  = '0;
    logic signed [14:0]     i_velocity_heading = '0;
    logic [23:0]            i_gondola_speed    = '0;
    logic                   o_out_valid;
    logic                   i_out_stall        = 1'b0;
    logic signed [15:0]     o_left_thrust;
    logic signed [15:0]     o_right_thrust;
    logic signed [15:0]     o_heading_setpoint;
    logic signed [14:0]     o_heading_error;

    t_heading_drive_model model = new();
    int in_gap_pct    = 0;
    int out_stall_pct = 0;
    int cycle_count   = 0;
    int n_writes      = 0;
    int n_settings    = 0;

    cascaded_heading_thrust_controller_core u_dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_gondola_heading  (i_gondola_heading),
        .i_velocity_heading (i_velocity_heading),
        .i_gondola_speed    (i_gondola_speed),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_left_thrust      (o_left_thrust),
        .o_right_thrust     (o_right_thrust),
        .o_heading_setpoint (o_heading_setpoint),
        .o_heading_error    (o_heading_error)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, model.pending());
            $display("cascaded_heading_thrust_controller_core verification failed");
            $finish;
        end
    end

    // result side: check each transfer, then pick the next stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            model.check_drive(t_drive'{o_left_thrust, o_right_thrust,
                                       o_heading_setpoint, o_heading_error});
        end
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // register write; the caller lowers the enable when done
    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        model.write_reg(idx, data);
        n_writes++;
    endtask

    task automatic apply_setting(input logic signed [14:0] tgt, input logic signed [15:0] thr,
                                 input logic [19:0] p_gain, input logic [19:0] d_gain,
                                 input logic [15:0] o_gain, input logic [13:0] lim,
                                 input logic [23:0] spd_thr);
        write_cfg(REG_TARGET_HEADING, CFG_DATA_W'($unsigned(tgt)));
        write_cfg(REG_TOTAL_THRUST, CFG_DATA_W'($unsigned(thr)));
        write_cfg(REG_INNER_P_GAIN, CFG_DATA_W'(p_gain));
        write_cfg(REG_INNER_D_GAIN, CFG_DATA_W'(d_gain));
        write_cfg(REG_OUTER_P_GAIN, CFG_DATA_W'(o_gain));
        write_cfg(REG_CORRECTION_LIMIT, CFG_DATA_W'(lim));
        write_cfg(REG_SPEED_THRESHOLD, spd_thr);
        i_cfg_we <= 1'b0;
        n_settings++;
    endtask

    // wait until every tick has produced its result
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (model.pending() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // one input transfer; valid stays high unless the next tick idles first
    task automatic send_tick(input logic signed [14:0] g_head,
                             input logic signed [14:0] v_head,
                             input logic [23:0] speed);
        while ($urandom_range(0, 99) < in_gap_pct) begin
            i_in_valid         <= 1'b0;
            i_gondola_heading  <= 15'($urandom);
            i_velocity_heading <= 15'($urandom);
            i_gondola_speed    <= 24'($urandom);
            @(posedge i_clk);
        end
        i_in_valid         <= 1'b1;
        i_gondola_heading  <= g_head;
        i_velocity_heading <= v_head;
        i_gondola_speed    <= speed;
        do begin
            @(posedge i_clk);
        end while (o_in_stall);
        model.record_tick(g_head, v_head, speed);
    endtask

    // mostly in-range headings with speeds around the threshold, some raw noise
    task automatic random_tick();
        int pick;
        logic signed [14:0] g_head, v_head;
        logic [23:0] speed;
        pick = $urandom_range(0, 9);
        if (pick < 3) begin
            g_head = 15'($urandom);
            v_head = 15'($urandom);
            speed  = 24'($urandom);
        end else begin
            g_head = 15'($urandom_range(0, 23039) - 11520);
            v_head = 15'($urandom_range(0, 23039) - 11520);
            case ($urandom_range(0, 4))
                0: speed = model.speed_threshold;
                1: speed = model.speed_threshold + 24'd1;
                2: speed = model.speed_threshold - 24'd1;
                3: speed = 24'($urandom) >> $urandom_range(0, 23);
                default: speed = 24'($urandom);
            endcase
        end
        send_tick(g_head, v_head, speed);
    endtask

    // stimulus
    initial begin
        int ph;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: threshold edges, heading extremes, wrap of out-of-range angles
        send_tick(15'sd0, 15'sd0, 24'd0);
        send_tick(15'sd100, -15'sd200, 24'd66);
        send_tick(15'sd100, -15'sd200, 24'd67);
        send_tick(15'sd100, -15'sd200, 24'd65);
        send_tick(-15'sd11520, 15'sd11519, 24'hFFFFFF);
        send_tick(15'sd11519, -15'sd11520, 24'hFFFFFF);
        send_tick(-15'sd16384, 15'sd16383, 24'hFFFFFF);
        send_tick(15'sd16383, -15'sd16384, 24'd0);
        send_tick(15'sd11520, -15'sd11521, 24'd1000);

        // full gains: split saturates both ways, limit above a half turn
        wait_drained();
        write_cfg(REG_SPARE, 24'($urandom));
        apply_setting(15'sd16383, -16'sd32768, 20'hFFFFF, 20'hFFFFF, 16'hFFFF,
                      14'h3FFF, 24'd0);
        send_tick(15'sd0, 15'sd11519, 24'd1);
        send_tick(15'sd0, -15'sd11520, 24'd1);
        send_tick(15'sd0, 15'sd0, 24'd0);
        send_tick(15'sd5000, -15'sd5000, 24'hFFFFFF);
        send_tick(-15'sd16384, 15'sd16383, 24'd7);

        // zero correction limit, threshold never exceeded
        wait_drained();
        apply_setting(-15'sd11520, 16'sd32767, 20'h00400, 20'h0, 16'h1000, 14'd0,
                      24'hFFFFFF);
        send_tick(15'sd11519, 15'sd0, 24'hFFFFFF);
        send_tick(-15'sd11520, 15'sd0, 24'hFFFFFF);
        send_tick(15'sd0, 15'sd0, 24'd0);

        // random phases, each with its own setting and idling mix
        for (ph = 0; ph < 8; ph++) begin
            wait_drained();
            case (ph)
                0: apply_setting(RST_TARGET_HEADING, RST_TOTAL_THRUST, RST_INNER_P_GAIN,
                                 RST_INNER_D_GAIN, RST_OUTER_P_GAIN, RST_CORRECTION_LIMIT,
                                 RST_SPEED_THRESHOLD);
                1: apply_setting(15'sd16383, 16'sd32767, 20'hFFFFF, 20'hFFFFF, 16'hFFFF,
                                 14'h3FFF, 24'hFFFFFF);
                2: apply_setting(-15'sd16384, -16'sd32768, 20'h0, 20'h0, 16'h0, 14'd0,
                                 24'd0);
                default: apply_setting(15'($urandom), 16'($urandom),
                                       20'($urandom) >> $urandom_range(0, 19),
                                       20'($urandom) >> $urandom_range(0, 19),
                                       16'($urandom) >> $urandom_range(0, 15),
                                       14'($urandom),
                                       24'($urandom) >> $urandom_range(0, 23));
            endcase
            case (ph % 4)
                0: begin
                    in_gap_pct    = 0;
                    out_stall_pct = 0;
                end
                1: begin
                    in_gap_pct    = 46;
                    out_stall_pct = 0;
                end
                2: begin
                    in_gap_pct    = 0;
                    out_stall_pct = 46;
                end
                default: begin
                    in_gap_pct    = 28;
                    out_stall_pct = 28;
                end
            endcase
            repeat (PHASE_TICKS) random_tick();
        end

        // drain and let the pipeline settle
        wait_drained();
        repeat (16) @(posedge i_clk);
        $display("Ran %0d control ticks, %0d results checked, over %0d register settings",
                 model.ticks, model.drives, n_settings);
        $display("(%0d register writes) with no idling, sender gaps, receiver stalls and both",
                 n_writes);
        if (model.mismatches == 0 && model.pending() == 0) begin
            $display("cascaded_heading_thrust_controller_core verification clean");
        end else begin
            $display("cascaded_heading_thrust_controller_core verification failed");
        end
        $finish;
    end

endmodule

### sim.f
sv/chtc_pkg.sv
sv/chtc_mul.sv
sv/cascaded_heading_thrust_controller_core.sv
verif/tb_cascaded_heading_thrust_controller_core.sv
